/* hdl/ppm_pkg.sv */
package ppm_pkg;

  // default configuration
  localparam int DIGIT_LIMIT_DEF = 31;
  localparam int QUEUE_DEPTH_DEF = 2;

  // status codes of a result
  localparam logic [1:0] ST_SCAN  = 2'd0;
  localparam logic [1:0] ST_DONE  = 2'd1;
  localparam logic [1:0] ST_NONE  = 2'd2;
  localparam logic [1:0] ST_ERROR = 2'd3;

  // sample depth codes
  localparam logic [1:0] DEPTH_UNKNOWN = 2'd0;
  localparam logic [1:0] DEPTH_8BIT    = 2'd1;
  localparam logic [1:0] DEPTH_16BIT   = 2'd2;

  // byte values of interest
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SIX   = 8'h36;
  localparam logic [7:0] CH_P     = 8'h50;

  // numeric limits
  localparam logic [16:0] VAL_SAT    = 17'd65536;
  localparam logic [16:0] MAXVAL_8   = 17'd255;
  localparam logic [16:0] MAXVAL_16  = 17'd65535;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } ppm_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [1:0]  sample_size;
    logic        depth_warning;
  } ppm_out_t;

  // classified byte as handed from front to back
  typedef struct packed {
    logic       eos;
    logic       hash;
    logic       top_space;
    logic       letter_p;
    logic       six;
    logic       digit;
    logic [3:0] digit_val;
    logic       cspace;
    logic       eol;
  } ppm_class_t;

endpackage

/* hdl/ppm_front.sv */
module ppm_front
  import ppm_pkg::*;
(
  input  ppm_in_t    item,
  output ppm_class_t cls
);

  logic [7:0] c;
  logic [7:0] c_off;

  assign c     = item.data_byte;
  assign c_off = c - CH_ZERO;

  // byte classification, all flags cleared on end of stream
  always_comb begin
    cls           = '0;
    cls.eos       = item.end_of_stream;
    cls.digit_val = c_off[3:0];
    if (!item.end_of_stream) begin
      cls.hash      = (c == CH_HASH);
      cls.eol       = (c == CH_LF) || (c == CH_CR);
      cls.top_space = (c == CH_SPACE) || (c == CH_LF) || (c == CH_TAB) || (c == CH_CR);
      cls.letter_p  = (c == CH_P);
      cls.six       = (c == CH_SIX);
      cls.digit     = (c >= CH_ZERO) && (c <= CH_NINE);
      cls.cspace    = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    end
  end

endmodule

/* hdl/ppm_queue.sv */
module ppm_queue
  import ppm_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  ppm_class_t push_data,
  output logic       full,
  input  logic       pop,
  output logic       not_empty,
  output ppm_class_t pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ppm_class_t             entries [DEPTH];
  logic [PTR_W-1:0]       wr_ptr;
  logic [PTR_W-1:0]       rd_ptr;
  logic [CNT_W-1:0]       count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = entries[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

/* hdl/ppm_back.sv */
module ppm_back
  import ppm_pkg::*;
#(
  parameter int DIGIT_LIMIT = DIGIT_LIMIT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  ppm_class_t q_data,
  output logic       q_pop,
  output logic       result_valid,
  input  logic       result_ready,
  output ppm_out_t   result_item
);

  localparam int CNT_W = $clog2(DIGIT_LIMIT + 1);

  typedef enum logic [5:0] {
    PH_TOP     = 6'b000001,
    PH_COMMENT = 6'b000010,
    PH_MAGIC   = 6'b000100,
    PH_WIDTH   = 6'b001000,
    PH_HEIGHT  = 6'b010000,
    PH_MAXVAL  = 6'b100000
  } phase_t;

  phase_t           phase, phase_next;
  logic [CNT_W-1:0] digit_count, digit_count_next;
  logic [16:0]      accumulator, accumulator_next;
  logic [15:0]      width_store, width_store_next;
  logic [15:0]      height_store, height_store_next;
  logic [1:0]       depth_code, depth_code_next;
  ppm_out_t         res_next;
  logic [20:0]      acc_scaled;
  logic [15:0]      acc_clamped;

  // step whenever the output register is free or being drained
  assign q_pop = q_valid && (!result_valid || result_ready);

  // accumulator times ten plus the new digit
  assign acc_scaled  = {1'b0, accumulator, 3'b000} + {3'b000, accumulator, 1'b0}
                       + {17'd0, q_data.digit_val};
  assign acc_clamped = accumulator[16] ? 16'hFFFF : accumulator[15:0];

  // header state update for one byte
  always_comb begin
    phase_next        = phase;
    digit_count_next  = digit_count;
    accumulator_next  = accumulator;
    width_store_next  = width_store;
    height_store_next = height_store;
    depth_code_next   = depth_code;
    res_next          = '0;
    res_next.status   = ST_SCAN;
    case (phase)
      PH_TOP: begin
        if (q_data.eos) begin
          res_next.status = ST_NONE;
        end else if (q_data.hash) begin
          phase_next = PH_COMMENT;
        end else if (q_data.top_space) begin
          phase_next = PH_TOP;
        end else if (q_data.letter_p) begin
          phase_next = PH_MAGIC;
        end else if (q_data.digit) begin
          phase_next       = PH_WIDTH;
          accumulator_next = {13'd0, q_data.digit_val};
          digit_count_next = CNT_W'(1);
        end else begin
          res_next.status = ST_NONE;
        end
      end
      PH_COMMENT: begin
        if (q_data.eos) begin
          res_next.status = ST_NONE;
        end else if (q_data.eol) begin
          phase_next = PH_TOP;
        end
      end
      PH_MAGIC: begin
        if (q_data.eos || !q_data.six) begin
          res_next.status = ST_ERROR;
        end else begin
          phase_next = PH_TOP;
        end
      end
      PH_WIDTH, PH_HEIGHT, PH_MAXVAL: begin
        if (q_data.eos) begin
          res_next.status = ST_ERROR;
        end else if (q_data.digit && (digit_count < CNT_W'(DIGIT_LIMIT))) begin
          accumulator_next = (acc_scaled > {4'd0, VAL_SAT}) ? VAL_SAT : acc_scaled[16:0];
          digit_count_next = digit_count + CNT_W'(1);
        end else if (q_data.cspace) begin
          if (phase == PH_WIDTH) begin
            width_store_next = acc_clamped;
            phase_next       = PH_HEIGHT;
          end else if (phase == PH_HEIGHT) begin
            height_store_next = acc_clamped;
            phase_next        = PH_MAXVAL;
          end else begin
            if (accumulator == MAXVAL_8) begin
              depth_code_next = DEPTH_8BIT;
            end else if (accumulator == MAXVAL_16) begin
              depth_code_next = DEPTH_16BIT;
            end else begin
              res_next.depth_warning = 1'b1;
            end
            res_next.status       = ST_DONE;
            res_next.image_width  = width_store;
            res_next.image_height = height_store;
          end
          accumulator_next = '0;
          digit_count_next = '0;
        end else begin
          res_next.status = ST_ERROR;
        end
      end
      default: begin
        phase_next = PH_TOP;
      end
    endcase
    // any final status starts a fresh search
    if (res_next.status != ST_SCAN) begin
      phase_next       = PH_TOP;
      digit_count_next = '0;
      accumulator_next = '0;
    end
    res_next.sample_size = depth_code_next;
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_TOP;
      digit_count  <= '0;
      accumulator  <= '0;
      width_store  <= '0;
      height_store <= '0;
      depth_code   <= DEPTH_UNKNOWN;
    end else if (q_pop) begin
      phase        <= phase_next;
      digit_count  <= digit_count_next;
      accumulator  <= accumulator_next;
      width_store  <= width_store_next;
      height_store <= height_store_next;
      depth_code   <= depth_code_next;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (q_pop) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      result_item <= res_next;
    end
  end

endmodule

/* hdl/ppm_header_parser.sv */
// a byte's result passes through the queue, then through the output register, after its byte transfer
// throughput: one byte per cycle while results are taken; a held result stalls the header step in the back end
// the classification queue lets the input side keep taking bytes while a result is held
// reset: synchronous, clears the queue, output valid and all parser state
// sample depth is cleared by reset only and persists across header searches
module ppm_header_parser
  import ppm_pkg::*;
#(
  parameter int DIGIT_LIMIT = DIGIT_LIMIT_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     byte_valid,
  output logic     byte_ready,
  input  ppm_in_t  byte_item,
  output logic     result_valid,
  input  logic     result_ready,
  output ppm_out_t result_item
);

  ppm_class_t cls;
  ppm_class_t q_data;
  logic       q_full;
  logic       q_valid;
  logic       q_pop;

  assign byte_ready = !q_full;

  // byte classification
  ppm_front u_front (
    .item (byte_item),
    .cls  (cls)
  );

  // decoupling queue
  ppm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (byte_valid && !q_full),
    .push_data (cls),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_data)
  );

  // header state machine and output register
  ppm_back #(
    .DIGIT_LIMIT (DIGIT_LIMIT)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_data       (q_data),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item)
  );

endmodule

/* dv/tb_ppm_header_parser.sv */
module tb_ppm_header_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import ppm_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_BYTES = 1400;

  // header search phases of the predictor
  typedef enum logic [2:0] {
    SCAN_TOP,
    SCAN_COMMENT,
    SCAN_MAGIC,
    SCAN_WIDTH,
    SCAN_HEIGHT,
    SCAN_MAXVAL
  } scan_phase_e;

  // patterns of the result sink
  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_COIN,
    SINK_SPARSE,
    SINK_COMB
  } sink_mode_e;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     byte_valid = 1'b0;
  logic     byte_ready;
  ppm_in_t  byte_item = '0;
  logic     result_valid;
  logic     result_ready = 1'b0;
  ppm_out_t result_item;

  ppm_in_t  stream_bytes[$];
  ppm_out_t results_due[$];

  // predictor state, cleared once at start of run
  scan_phase_e scan_ph = SCAN_TOP;
  int unsigned ndig = 0;
  logic [16:0] acc_val = '0;
  logic [15:0] w_store = '0;
  logic [15:0] h_store = '0;
  logic [1:0]  depth = DEPTH_UNKNOWN;

  int unsigned cycle_no = 0;
  int unsigned fails = 0;
  int unsigned bytes_sent = 0;
  int unsigned n_done = 0;
  int unsigned n_warn = 0;
  int unsigned n_wide = 0;
  int unsigned n_none = 0;
  int unsigned n_err = 0;

  ppm_header_parser u_dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .byte_item    (byte_item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item)
  );

  always #2 clk = ~clk;

  // one parser step: updates predictor state and returns the result it gives
  function automatic ppm_out_t parse_byte(input ppm_in_t b);
    ppm_out_t    r;
    logic [7:0]  c;
    logic        is_dig;
    logic        is_ws;
    logic [31:0] grown;
    r = '0;
    c = b.data_byte;
    is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
    is_ws = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    r.status = ST_SCAN;
    case (scan_ph)
      SCAN_TOP: begin
        if (b.end_of_stream) begin
          r.status = ST_NONE;
        end else if (c == CH_HASH) begin
          scan_ph = SCAN_COMMENT;
        end else if (c == CH_SPACE || c == CH_LF || c == CH_TAB || c == CH_CR) begin
          scan_ph = SCAN_TOP;
        end else if (c == CH_P) begin
          scan_ph = SCAN_MAGIC;
        end else if (is_dig) begin
          scan_ph = SCAN_WIDTH;
          acc_val = 17'(c - CH_ZERO);
          ndig = 1;
        end else begin
          r.status = ST_NONE;
        end
      end
      SCAN_COMMENT: begin
        if (b.end_of_stream) r.status = ST_NONE;
        else if (c == CH_LF || c == CH_CR) scan_ph = SCAN_TOP;
      end
      SCAN_MAGIC: begin
        if (b.end_of_stream || c != CH_SIX) r.status = ST_ERROR;
        else scan_ph = SCAN_TOP;
      end
      default: begin
        if (b.end_of_stream) begin
          r.status = ST_ERROR;
        end else if (is_dig && ndig < DIGIT_LIMIT_DEF) begin
          grown = 32'(acc_val) * 32'd10 + 32'(c - CH_ZERO);
          acc_val = (grown > 32'(VAL_SAT)) ? VAL_SAT : grown[16:0];
          ndig++;
        end else if (is_ws) begin
          if (scan_ph == SCAN_WIDTH) begin
            w_store = (acc_val > MAXVAL_16) ? 16'hFFFF : acc_val[15:0];
            scan_ph = SCAN_HEIGHT;
          end else if (scan_ph == SCAN_HEIGHT) begin
            h_store = (acc_val > MAXVAL_16) ? 16'hFFFF : acc_val[15:0];
            scan_ph = SCAN_MAXVAL;
          end else begin
            if (acc_val == MAXVAL_8) depth = DEPTH_8BIT;
            else if (acc_val == MAXVAL_16) depth = DEPTH_16BIT;
            else r.depth_warning = 1'b1;
            r.status = ST_DONE;
            r.image_width = w_store;
            r.image_height = h_store;
          end
          acc_val = '0;
          ndig = 0;
        end else begin
          r.status = ST_ERROR;
        end
      end
    endcase
    // any final status starts a fresh search
    if (r.status != ST_SCAN) begin
      scan_ph = SCAN_TOP;
      ndig = 0;
      acc_val = '0;
    end
    r.sample_size = depth;
    return r;
  endfunction

  // stream building helpers
  task automatic push_byte(input logic [7:0] c);
    stream_bytes.push_back('{data_byte: c, end_of_stream: 1'b0});
  endtask

  task automatic push_eos();
    stream_bytes.push_back('{data_byte: 8'($urandom), end_of_stream: 1'b1});
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  // any C whitespace byte, vertical tab and form feed included
  function automatic logic [7:0] pick_space();
    int unsigned k;
    k = $urandom_range(0, 5);
    return (k == 5) ? CH_SPACE : CH_TAB + 8'(k);
  endfunction

  function automatic int unsigned pick_value();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return $urandom_range(1000, 70000);
      2: return MAXVAL_16;
      3: return VAL_SAT;
      default: return $urandom_range(0, 999);
    endcase
  endfunction

  // top-level filler: blank bytes or a comment line
  task automatic add_filler();
    logic [7:0] c;
    case ($urandom_range(0, 4))
      0: push_byte(CH_SPACE);
      1: push_byte(CH_TAB);
      2: push_byte(CH_CR);
      3: push_byte(CH_LF);
      default: begin
        push_byte(CH_HASH);
        repeat ($urandom_range(0, 8)) begin
          c = 8'($urandom);
          if (c == CH_LF || c == CH_CR) c = CH_HASH;
          push_byte(c);
        end
        push_byte($urandom_range(0, 1) ? CH_LF : CH_CR);
      end
    endcase
  endtask

  // decimal number with terminator; a long run lands on or just past the digit limit
  task automatic add_number(input int unsigned v, input bit long_run);
    string s;
    s = $sformatf("%0d", v);
    if (long_run) repeat (DIGIT_LIMIT_DEF - s.len() + $urandom_range(0, 1)) push_byte(CH_ZERO);
    push_text(s);
    push_byte(pick_space());
  endtask

  task automatic add_header();
    repeat ($urandom_range(0, 2)) add_filler();
    if ($urandom_range(0, 3) != 0) begin
      push_text("P6");
      repeat ($urandom_range(0, 2)) add_filler();
    end
    add_number(pick_value(), $urandom_range(0, 19) == 0);
    if ($urandom_range(0, 7) == 0) push_byte(pick_space());
    else add_number(pick_value(), $urandom_range(0, 19) == 0);
    case ($urandom_range(0, 6))
      0, 1: add_number(MAXVAL_8, $urandom_range(0, 19) == 0);
      2, 3: add_number(MAXVAL_16, 1'b0);
      4, 5: add_number(pick_value(), $urandom_range(0, 19) == 0);
      default: push_byte(pick_space());
    endcase
  endtask

  // mostly clean headers, some cut short or corrupted, some noise
  task automatic add_case();
    int unsigned kind;
    int unsigned mark;
    int unsigned cut;
    kind = $urandom_range(0, 99);
    if (kind >= 88) begin
      repeat ($urandom_range(1, 6)) push_byte(8'($urandom));
      push_eos();
    end else begin
      mark = stream_bytes.size();
      add_header();
      if (kind >= 70) begin
        cut = $urandom_range(mark, stream_bytes.size() - 1);
        while (stream_bytes.size() > cut) void'(stream_bytes.pop_back());
        if ($urandom_range(0, 1)) push_byte(8'($urandom));
        push_eos();
      end else if ($urandom_range(0, 5) == 0) begin
        push_eos();
      end
    end
  endtask

  // byte driver: bursts of random length, random gaps between them
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else begin
      if (byte_valid && byte_ready) begin
        results_due.push_back(parse_byte(byte_item));
        bytes_sent++;
      end
      if (!byte_valid || byte_ready) begin
        if (burst_left == 0 && gap_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
        if (burst_left > 0 && stream_bytes.size() != 0) begin
          byte_valid <= 1'b1;
          byte_item <= stream_bytes.pop_front();
          burst_left--;
        end else begin
          byte_valid <= 1'b0;
          if (burst_left == 0 && gap_left > 0) gap_left--;
        end
      end
    end
  end

  // result sink: stalls in one of four patterns, picked at random and switched during the run
  sink_mode_e sink_mode = SINK_OPEN;

  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (cycle_no % 256 == 0) sink_mode = sink_mode_e'($urandom_range(0, 3));
      case (sink_mode)
        SINK_OPEN:   result_ready <= 1'b1;
        SINK_COIN:   result_ready <= 1'($urandom_range(0, 1));
        SINK_SPARSE: result_ready <= ($urandom_range(0, 7) == 0);
        default:     result_ready <= (cycle_no % 16 < 11);
      endcase
    end
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  // monitor: compare each result transfer with the oldest pending expected result
  always @(posedge clk) begin
    ppm_out_t want;
    if (!rst && result_valid && result_ready) begin
      if (results_due.size() == 0) begin
        $error("result transfer with nothing pending, status %0d", result_item.status);
        fails++;
      end else begin
        want = results_due.pop_front();
        check_field("status", want.status, result_item.status);
        check_field("image_width", want.image_width, result_item.image_width);
        check_field("image_height", want.image_height, result_item.image_height);
        check_field("sample_size", want.sample_size, result_item.sample_size);
        check_field("depth_warning", want.depth_warning, result_item.depth_warning);
        case (want.status)
          ST_DONE: begin
            n_done++;
            if (want.depth_warning) n_warn++;
            if (want.sample_size == DEPTH_16BIT) n_wide++;
          end
          ST_NONE:  n_none++;
          ST_ERROR: n_err++;
          default: ;
        endcase
      end
    end
  end

  // cycle count and watchdog
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (cycle_no > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned directed_len;
    // end of stream at top level, then inside a comment
    push_eos();
    push_text("#x");
    push_eos();
    // bad magic, magic cut by end of stream, stray top-level byte
    push_text("P5");
    push_byte(CH_P);
    push_eos();
    push_text("!");
    // clean header with empty height, 8-bit samples
    push_text("P6 9\t\n255 ");
    // saturated width and saturated maxval
    push_text("99999 1 65536");
    push_byte(8'h0B);
    // bad byte and end of stream inside a number
    push_text("4x3");
    push_eos();
    directed_len = stream_bytes.size();
    while (stream_bytes.size() < directed_len + RANDOM_BYTES) add_case();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (stream_bytes.size() != 0 || byte_valid || results_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("covered %0d bytes: %0d headers (%0d with depth warning, %0d sixteen-bit)",
             bytes_sent, n_done, n_warn, n_wide);
    $display("  %0d searches ended without header, %0d ended in error", n_none, n_err);
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* ppm_header_parser.f */
hdl/ppm_pkg.sv
hdl/ppm_front.sv
hdl/ppm_queue.sv
hdl/ppm_back.sv
hdl/ppm_header_parser.sv
dv/tb_ppm_header_parser.sv
